// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sum tree core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, disabled while arst_n is low.
`define PST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true on a rising edge of clk.
`define PST_NEVER(lbl, expr, msg) \
	`PST_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/pst_pkg.sv =====
// Types and constants of the priority sum tree.
package pst_pkg;

	localparam int SUM_W  = 42;
	localparam int PRIO_W = 32;
	localparam int LEAF_W = 10;
	localparam int FILL_W = 11;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [PRIO_W-1:0] INIT_MAX_PRIO = 32'd65536;

	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FILLED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO      = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF_WR,
		ST_UP_RD,
		ST_UP_WR,
		ST_DN_RD,
		ST_DN_CMP,
		ST_LEAF_RD,
		ST_LEAF_DATA,
		ST_FINISH
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             flag;
	} alu_res_t;

endpackage

// ===== rtl/pst_node_ram.sv =====
// Node memory of the sum tree: one write port and one registered read port.
module pst_node_ram #(
	parameter int ADDR_W = 11
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [pst_pkg::SUM_W-1:0] wdata,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [pst_pkg::SUM_W-1:0] rdata
);
	import pst_pkg::*;

	logic [SUM_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pst_alu.sv =====
// Shared adder of the sum tree: saturating add, or subtract with a less-or-equal flag.
module pst_alu (
	input  pst_pkg::alu_op_t          op,
	input  logic [pst_pkg::SUM_W-1:0] a,
	input  logic [pst_pkg::SUM_W-1:0] b,
	output pst_pkg::alu_res_t         res
);
	import pst_pkg::*;

	logic [SUM_W:0] b_ext;
	logic [SUM_W:0] s;

	always_comb begin
		b_ext = (op == ALU_SUB) ? ~{1'b0, b} : {1'b0, b};
		s = {1'b0, a} + b_ext + {{SUM_W{1'b0}}, (op == ALU_SUB)};
		unique case (op)
			ALU_ADD: begin
				res.value = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
				res.flag  = s[SUM_W];
			end
			ALU_SUB: begin
				res.value = s[SUM_W-1:0];
				res.flag  = s[SUM_W] | (s[SUM_W-1:0] == '0);
			end
			default: begin
				res.value = s[SUM_W-1:0];
				res.flag  = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/priority_sum_tree_core.sv =====
// Top level of the priority sum tree: sequencer, state registers and result registers.
//
// After reset the block clears its node memory, one node a cycle, with busy high throughout.
// An append or update writes the leaf and walks up the tree, a search walks down and reads the
// leaf, and a request answered at once (full buffer, unfilled leaf, zero total, unused kind)
// goes straight to the finish state. Each level up takes one read and one write of the single
// node memory through the shared adder; each level down, one read and one compare. The result
// is shown for exactly one cycle with done high, in the first idle cycle, and cannot be held
// off by the receiver. A configuration write loads the running maximum priority directly.
`include "assert_macros.svh"

module priority_sum_tree_core #(
	parameter int CAPACITY = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cfg_wr_en,
	input  logic [pst_pkg::PRIO_W-1:0] cfg_wr_data,
	input  logic [pst_pkg::REQ_W-1:0]  req_type,
	input  logic [pst_pkg::LEAF_W-1:0] leaf_index,
	input  logic [pst_pkg::PRIO_W-1:0] new_priority,
	input  logic [pst_pkg::SUM_W-1:0]  search_value,
	output logic                       done,
	output logic [pst_pkg::STAT_W-1:0] status,
	output logic [pst_pkg::LEAF_W-1:0] found_leaf,
	output logic [pst_pkg::PRIO_W-1:0] found_priority,
	output logic [pst_pkg::SUM_W-1:0]  total_priority,
	output logic [pst_pkg::FILL_W-1:0] fill_level
);
	import pst_pkg::*;

	localparam int LW = $clog2(CAPACITY);
	localparam int NW = LW + 1;
	localparam int FW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [NW-1:0]     clr_q;
	logic [LW-1:0]     wp_q;
	logic [FW-1:0]     fill_q;
	logic [SUM_W-1:0]  total_q;
	logic [PRIO_W-1:0] run_max_q;
	logic              done_q;

	logic [NW-1:0]     h_q;
	logic [SUM_W-1:0]  val_q;
	logic [SUM_W-1:0]  tgt_q;
	logic [STAT_W-1:0] status_q;
	logic [LEAF_W-1:0] res_leaf_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic [SUM_W-1:0]  res_total_q;
	logic [FILL_W-1:0] res_fill_q;

	logic              mem_we;
	logic [NW-1:0]     mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;
	logic [NW-1:0]     mem_raddr;
	logic [SUM_W-1:0]  mem_rdata;

	alu_op_t           alu_op;
	logic [SUM_W-1:0]  alu_a;
	logic [SUM_W-1:0]  alu_b;
	alu_res_t          alu_res;

	logic              accept;
	logic              is_full;
	logic              is_unfilled;
	logic [31:0]       leaf_wide;
	logic [31:0]       wp_wide;
	logic [31:0]       fill_wide;
	logic [NW-1:0]     h_down;
	logic [NW-1:0]     h_parent;
	logic [31:0]       h_leaf_wide;

	pst_node_ram #(
		.ADDR_W(NW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pst_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign leaf_wide   = 32'(leaf_index);
	assign wp_wide     = 32'(wp_q);
	assign fill_wide   = 32'(fill_q);
	assign is_full     = (fill_q == FW'(CAPACITY));
	assign is_unfilled = (leaf_wide >= fill_wide);
	assign h_down      = {h_q[NW-2:0], ~alu_res.flag};
	assign h_parent    = {1'b0, h_q[NW-1:1]};
	assign h_leaf_wide = 32'(h_q[LW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = h_q;
		mem_wdata = val_q;
		mem_raddr = h_q;
		alu_op    = ALU_ADD;
		alu_a     = val_q;
		alu_b     = mem_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_APPEND: state_d = is_full ? ST_FINISH : ST_LEAF_WR;
						REQ_UPDATE: state_d = is_unfilled ? ST_FINISH : ST_LEAF_WR;
						REQ_SEARCH: state_d = (total_q == '0) ? ST_FINISH : ST_DN_RD;
						default:    state_d = ST_FINISH;
					endcase
				end
			end
			ST_LEAF_WR: begin
				mem_we  = 1'b1;
				state_d = ST_UP_RD;
			end
			ST_UP_RD: begin
				mem_raddr = h_q ^ NW'(1);
				state_d   = ST_UP_WR;
			end
			ST_UP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = h_parent;
				mem_wdata = alu_res.value;
				state_d   = (h_parent == NW'(1)) ? ST_FINISH : ST_UP_RD;
			end
			ST_DN_RD: begin
				mem_raddr = {h_q[NW-2:0], 1'b0};
				state_d   = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				alu_op  = ALU_SUB;
				alu_a   = tgt_q;
				state_d = h_down[NW-1] ? ST_LEAF_RD : ST_DN_RD;
			end
			ST_LEAF_RD: begin
				state_d = ST_LEAF_DATA;
			end
			ST_LEAF_DATA: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			run_max_q <= INIT_MAX_PRIO;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cfg_wr_en) begin
				run_max_q <= cfg_wr_data;
			end
			if (accept && req_type == REQ_APPEND && !is_full) begin
				wp_q   <= wp_q + LW'(1);
				fill_q <= fill_q + FW'(1);
			end
			if (accept && req_type == REQ_UPDATE && !is_unfilled && new_priority > run_max_q) begin
				run_max_q <= new_priority;
			end
			if (state_q == ST_UP_WR && h_parent == NW'(1)) begin
				total_q <= alu_res.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					status_q   <= STAT_OK;
					res_leaf_q <= '0;
					res_prio_q <= '0;
					tgt_q      <= search_value;
					h_q        <= NW'(1);
					unique case (req_type)
						REQ_APPEND: begin
							if (is_full) begin
								status_q <= STAT_FULL;
							end else begin
								res_leaf_q <= wp_wide[LEAF_W-1:0];
								res_prio_q <= run_max_q;
								h_q        <= {1'b1, wp_q};
								val_q      <= SUM_W'(run_max_q);
							end
						end
						REQ_UPDATE: begin
							if (is_unfilled) begin
								status_q <= STAT_NOT_FILLED;
							end else begin
								res_leaf_q <= leaf_index;
								res_prio_q <= new_priority;
								h_q        <= {1'b1, leaf_wide[LW-1:0]};
								val_q      <= SUM_W'(new_priority);
							end
						end
						REQ_SEARCH: begin
							if (total_q == '0) begin
								status_q <= STAT_ZERO;
							end
						end
						default: begin
							status_q <= STAT_OK;
						end
					endcase
				end
			end
			ST_UP_WR: begin
				val_q <= alu_res.value;
				h_q   <= h_parent;
			end
			ST_DN_CMP: begin
				h_q <= h_down;
				if (!alu_res.flag) begin
					tgt_q <= alu_res.value;
				end
			end
			ST_LEAF_DATA: begin
				res_leaf_q <= h_leaf_wide[LEAF_W-1:0];
				res_prio_q <= mem_rdata[PRIO_W-1:0];
			end
			ST_FINISH: begin
				res_total_q <= total_q;
				res_fill_q  <= fill_wide[FILL_W-1:0];
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_leaf     = res_leaf_q;
	assign found_priority = res_prio_q;
	assign total_priority = res_total_q;
	assign fill_level     = res_fill_q;

	`PST_NEVER(a_fill_bound, fill_q > FW'(CAPACITY), "Fill count exceeds the capacity.")
	`PST_ASSERT(a_done_after_finish, done_q |-> $past(state_q == ST_FINISH), "Result strobe without a finished item.")
	`PST_ASSERT(a_reject_clean, (done_q && status_q != STAT_OK) |-> (res_leaf_q == '0 && res_prio_q == '0), "Rejected item reports a leaf.")
	`PST_ASSERT(a_accept_busy, accept |=> busy, "Accepted item did not raise busy.")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the priority sum tree core: directed table, then random phases.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pst_pkg::*;

	localparam int CAPACITY = 1024;
	localparam int NODE_COUNT = 2 * CAPACITY - 1;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [LEAF_W-1:0] leaf;
		logic [PRIO_W-1:0] prio;
		logic [SUM_W-1:0]  target;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LEAF_W-1:0] leaf;
		logic [PRIO_W-1:0] prio;
		logic [SUM_W-1:0]  total;
		logic [FILL_W-1:0] fill;
	} answer_t;

	typedef struct packed {
		request_t rq;
		bit       typed;
		answer_t  ans;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_wr_en;
	logic [PRIO_W-1:0] cfg_wr_data;
	logic [REQ_W-1:0]  req_type;
	logic [LEAF_W-1:0] leaf_index;
	logic [PRIO_W-1:0] new_priority;
	logic [SUM_W-1:0]  search_value;
	logic done;
	logic [STAT_W-1:0] status;
	logic [LEAF_W-1:0] found_leaf;
	logic [PRIO_W-1:0] found_priority;
	logic [SUM_W-1:0]  total_priority;
	logic [FILL_W-1:0] fill_level;

	priority_sum_tree_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req_type      (req_type),
		.leaf_index    (leaf_index),
		.new_priority  (new_priority),
		.search_value  (search_value),
		.done          (done),
		.status        (status),
		.found_leaf    (found_leaf),
		.found_priority(found_priority),
		.total_priority(total_priority),
		.fill_level    (fill_level)
	);

	logic [SUM_W-1:0]  node_sum [0:NODE_COUNT-1];
	int unsigned       ring_ptr;
	int unsigned       filled;
	logic [PRIO_W-1:0] max_prio;

	answer_t    pending_answers[$];
	table_row_t directed_rows[$];
	int unsigned mismatches;
	int unsigned burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	task automatic write_leaf(input int unsigned leaf, input logic [PRIO_W-1:0] prio);
		int unsigned node;
		int unsigned parent;
		node = leaf + CAPACITY - 1;
		node_sum[node] = {{(SUM_W-PRIO_W){1'b0}}, prio};
		while (node > 0) begin
			parent = (node - 1) / 2;
			node_sum[parent] = sat_sum(node_sum[2*parent+1], node_sum[2*parent+2]);
			node = parent;
		end
	endtask

	task automatic predict_request(input request_t rq, output answer_t ans);
		int unsigned node;
		logic [SUM_W-1:0] tgt;
		logic [SUM_W-1:0] lv;
		ans = '0;
		ans.status = STAT_OK;
		case (rq.req)
			REQ_APPEND: begin
				if (filled >= CAPACITY) begin
					ans.status = STAT_FULL;
				end else begin
					ans.leaf = ring_ptr[LEAF_W-1:0];
					ans.prio = max_prio;
					write_leaf(ring_ptr, max_prio);
					ring_ptr = (ring_ptr + 1) % CAPACITY;
					filled++;
				end
			end
			REQ_UPDATE: begin
				if (rq.leaf >= filled) begin
					ans.status = STAT_NOT_FILLED;
				end else begin
					if (rq.prio > max_prio)
						max_prio = rq.prio;
					write_leaf(rq.leaf, rq.prio);
					ans.leaf = rq.leaf;
					ans.prio = rq.prio;
				end
			end
			REQ_SEARCH: begin
				if (node_sum[0] == '0) begin
					ans.status = STAT_ZERO;
				end else begin
					node = 0;
					tgt = rq.target;
					while (node < CAPACITY - 1) begin
						lv = node_sum[2*node+1];
						if (tgt <= lv) begin
							node = 2 * node + 1;
						end else begin
							tgt = tgt - lv;
							node = 2 * node + 2;
						end
					end
					ans.leaf = LEAF_W'(node - (CAPACITY - 1));
					ans.prio = node_sum[node][PRIO_W-1:0];
				end
			end
			default: begin
			end
		endcase
		ans.total = node_sum[0];
		ans.fill = filled[FILL_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		answer_t exp_ans;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(status), 64'(0));
			end else begin
				exp_ans = pending_answers.pop_front();
				if (status !== exp_ans.status)
					report_mismatch("status", 64'(status), 64'(exp_ans.status));
				if (found_leaf !== exp_ans.leaf)
					report_mismatch("found_leaf", 64'(found_leaf), 64'(exp_ans.leaf));
				if (found_priority !== exp_ans.prio)
					report_mismatch("found_priority", 64'(found_priority),
						64'(exp_ans.prio));
				if (total_priority !== exp_ans.total)
					report_mismatch("total_priority", 64'(total_priority),
						64'(exp_ans.total));
				if (fill_level !== exp_ans.fill)
					report_mismatch("fill_level", 64'(fill_level), 64'(exp_ans.fill));
			end
		end
	end

	task automatic send_item(input request_t rq, input bit typed, input answer_t typed_ans);
		answer_t pred;
		int unsigned gap;
		start <= 1'b1;
		req_type <= rq.req;
		leaf_index <= rq.leaf;
		new_priority <= rq.prio;
		search_value <= rq.target;
		do @(posedge clk); while (busy);
		predict_request(rq, pred);
		pending_answers.insert(pending_answers.size(), typed ? typed_ans : pred);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic add_row(input logic [REQ_W-1:0] req, input logic [LEAF_W-1:0] leaf,
			input logic [PRIO_W-1:0] prio, input logic [SUM_W-1:0] target, input bit typed,
			input logic [STAT_W-1:0] st, input logic [LEAF_W-1:0] fl,
			input logic [PRIO_W-1:0] fp, input logic [SUM_W-1:0] tot,
			input logic [FILL_W-1:0] fill);
		table_row_t row;
		row.rq = '{req: req, leaf: leaf, prio: prio, target: target};
		row.typed = typed;
		row.ans = '{status: st, leaf: fl, prio: fp, total: tot, fill: fill};
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic drain_and_write_max(input logic [PRIO_W-1:0] value);
		start <= 1'b0;
		while (pending_answers.size() > 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_prio = value;
	endtask

	task automatic pick_priority(output logic [PRIO_W-1:0] prio);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			prio = '0;
		else if (r == 1)
			prio = '1;
		else if (r < 6)
			prio = $urandom_range(0, 1 << 20);
		else
			prio = $urandom;
	endtask

	task automatic run_phase(input int unsigned n_items, input int unsigned append_pct,
			input bit stop_when_full);
		request_t rq;
		answer_t none;
		logic [63:0] wide;
		logic [63:0] span;
		int unsigned r;
		none = '0;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (stop_when_full && filled >= CAPACITY)
				break;
			wide = {$urandom, $urandom};
			rq.leaf = LEAF_W'($urandom);
			rq.prio = $urandom;
			rq.target = wide[SUM_W-1:0];
			if ($urandom_range(0, 99) < append_pct) begin
				rq.req = REQ_APPEND;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					rq.req = REQ_UPDATE;
					if (filled > 0 && $urandom_range(0, 99) < 85)
						rq.leaf = LEAF_W'($urandom_range(0, filled - 1));
					pick_priority(rq.prio);
				end else if (r < 92) begin
					rq.req = REQ_SEARCH;
					r = $urandom_range(0, 9);
					span = {22'd0, node_sum[0]} + 64'd1;
					if (r == 0)
						rq.target = '0;
					else if (r == 1)
						rq.target = node_sum[0];
					else if (r < 9)
						rq.target = SUM_W'(wide % span);
				end else begin
					rq.req = REQ_UNUSED;
				end
			end
			send_item(rq, 1'b0, none);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_type = '0;
		leaf_index = '0;
		new_priority = '0;
		search_value = '0;
		mismatches = 0;
		burst_left = 0;
		for (int i = 0; i < NODE_COUNT; i++)
			node_sum[i] = '0;
		ring_ptr = 0;
		filled = 0;
		max_prio = INIT_MAX_PRIO;

		add_row(REQ_SEARCH, '0, '0, '0, 1'b1, STAT_ZERO, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '1, '1, '1, 1'b1, STAT_ZERO, '0, '0, '0, '0);
		add_row(REQ_UPDATE, '0, 32'd1, '0, 1'b1, STAT_NOT_FILLED, '0, '0, '0, '0);
		add_row(REQ_UPDATE, '1, '1, '1, 1'b1, STAT_NOT_FILLED, '0, '0, '0, '0);
		add_row(REQ_UNUSED, 10'h155, 32'hA5A5_A5A5, 42'h2AA_AAAA_AAAA, 1'b1, STAT_OK,
			'0, '0, '0, '0);
		add_row(REQ_APPEND, '1, '1, '1, 1'b1, STAT_OK, 10'd0, INIT_MAX_PRIO, 42'd65536,
			11'd1);
		add_row(REQ_APPEND, '0, '0, '0, 1'b1, STAT_OK, 10'd1, INIT_MAX_PRIO, 42'd131072,
			11'd2);
		add_row(REQ_UPDATE, 10'd1, '1, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_UPDATE, 10'd2, 32'd5, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_APPEND, '0, '0, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'd0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'd65536, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'd65537, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, '1, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_UPDATE, 10'd0, '0, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'd0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'd1, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_UPDATE, '1, '0, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_APPEND, '0, '0, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_UPDATE, 10'd3, 32'd1, '0, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_SEARCH, '0, '0, 42'h1_0000_0000, 1'b0, STAT_OK, '0, '0, '0, '0);
		add_row(REQ_UNUSED, '1, '1, '1, 1'b0, STAT_OK, '0, '0, '0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].ans);

		drain_and_write_max('0);
		run_phase(300, 45, 1'b0);
		drain_and_write_max('1);
		run_phase(300, 45, 1'b0);
		drain_and_write_max($urandom);
		run_phase(300, 45, 1'b0);
		drain_and_write_max($urandom_range(0, 1 << 18));
		run_phase(3000, 85, 1'b1);
		run_phase(200, 40, 1'b0);

		start <= 1'b0;
		while (pending_answers.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_node_ram.sv
rtl/pst_alu.sv
rtl/priority_sum_tree_core.sv
tb/testbench.sv
